>>> rtl/ckim_pkg.sv
// Shared sizes and the item record that travels along the cell chain.
package ckim_pkg;

    localparam int ENTRIES    = 256;
    localparam int COORD_BITS = 12;
    localparam int VALUE_BITS = 16;

    // Operation codes carried in the func field
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // One item in flight, plus what the cells passed so far have learned about it
    typedef struct packed {
        logic                  vld;
        logic                  func;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [VALUE_BITS-1:0] value_in;
        logic                  found;
        logic [VALUE_BITS-1:0] value_out;
        logic                  placed;
    } t_item;

endpackage

>>> rtl/ckim_req_if.sv
// Request channel: one lookup or insert item.
interface ckim_req_if;
    import ckim_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [VALUE_BITS-1:0] value_in;

    modport source (output valid, output func, output col, output row,
                    output value_in, input ready);
    modport sink   (input valid, input func, input col, input row,
                    input value_in, output ready);
endinterface

>>> rtl/ckim_rsp_if.sv
// Response channel: one result item per request.
interface ckim_rsp_if;
    import ckim_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    logic                  full_res;

    modport source (output valid, output found, output value_out,
                    output full_res, input ready);
    modport sink   (input valid, input found, input value_out,
                    input full_res, output ready);
endinterface

>>> rtl/coordinate_keyed_index_map.sv
// Top level: coordinate-keyed index map built as a chain of entry cells.
//
//  channel  dir  handshake      payload
//  i_req    in   valid/ready    func, col, row, value_in
//  o_rsp    out  valid/ready    found, value_out, full_res
//
// Each item walks the chain one cell per cycle while the output is not stalled. The
// accepting edge loads the first cell's stage register; the item then passes one cell
// stage per entry, then the output register. Items follow each other every cycle.
// Reset clears every entry's valid bit and the stage flags at once.
// A stalled output freezes the whole chain; ready drops only then.
module coordinate_keyed_index_map (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ckim_req_if.sink   i_req,
    ckim_rsp_if.source o_rsp
);
    import ckim_pkg::*;

    t_item                 w_chain [ENTRIES+1];
    logic                  w_adv;
    logic                  r_out_valid;
    logic                  r_found;
    logic [VALUE_BITS-1:0] r_value_out;
    logic                  r_full_res;

    // Chain moves whenever the output register is free or being drained
    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_adv;

    // Item entering the first cell
    always_comb begin
        w_chain[0].vld       = i_req.valid && w_adv;
        w_chain[0].func      = i_req.func;
        w_chain[0].col       = i_req.col;
        w_chain[0].row       = i_req.row;
        w_chain[0].value_in  = i_req.value_in;
        w_chain[0].found     = 1'b0;
        w_chain[0].value_out = '0;
        w_chain[0].placed    = 1'b0;
    end

    // Row of entry cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ckim_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_item  (w_chain[g]),
            .o_item  (w_chain[g+1])
        );
    end

    // Output register; a new key that found no free cell is reported full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_chain[ENTRIES].vld;
            r_found     <= w_chain[ENTRIES].found;
            r_value_out <= w_chain[ENTRIES].value_out;
            r_full_res  <= (w_chain[ENTRIES].func == FUNC_INSERT) &&
                           !w_chain[ENTRIES].found && !w_chain[ENTRIES].placed;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.found     = r_found;
    assign o_rsp.value_out = r_value_out;
    assign o_rsp.full_res  = r_full_res;

endmodule

>>> rtl/ckim_cell.sv
// One table entry plus one pipeline stage of the search chain.
module ckim_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  ckim_pkg::t_item i_item,
    output ckim_pkg::t_item o_item
);
    import ckim_pkg::*;

    logic                  r_e_valid;
    logic [COORD_BITS-1:0] r_e_col;
    logic [COORD_BITS-1:0] r_e_row;
    logic [VALUE_BITS-1:0] r_e_value;
    t_item                 r_item;

    t_item n_item;
    logic  w_match;
    logic  w_claim;
    logic  w_write;

    // Compare against the stored key; claim this entry if it is the first free one
    always_comb begin
        w_match = i_item.vld && r_e_valid && !i_item.found &&
                  (r_e_col == i_item.col) && (r_e_row == i_item.row);
        w_claim = i_item.vld && !r_e_valid && (i_item.func == FUNC_INSERT) &&
                  !i_item.found && !i_item.placed;
        w_write = w_claim || (w_match && (i_item.func == FUNC_INSERT));
        n_item  = i_item;
        if (w_match) begin
            n_item.found = 1'b1;
            if (i_item.func == FUNC_LOOKUP) begin
                n_item.value_out = r_e_value;
            end
        end
        if (w_claim) begin
            n_item.placed = 1'b1;
        end
    end

    // Valid bit of the entry and the stage flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid  <= 1'b0;
            r_item.vld <= 1'b0;
        end else if (i_adv) begin
            if (w_claim) begin
                r_e_valid <= 1'b1;
            end
            r_item <= n_item;
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (i_adv && w_claim) begin
            r_e_col <= i_item.col;
            r_e_row <= i_item.row;
        end
        if (i_adv && w_write) begin
            r_e_value <= i_item.value_in;
        end
    end

    assign o_item = r_item;

endmodule

>>> tb/tb.sv
// Testbench for coordinate_keyed_index_map: directed rows, then random lookups and inserts.
`timescale 1ns / 1ps

module tb;
    import ckim_pkg::*;

    localparam int N_ITEMS     = 1450;
    localparam int KEY_POOL    = 320;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 700;
    localparam int DRAIN       = 2 * ENTRIES + 20;
    localparam int LIMIT       = 200000;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] value_out;
        logic                  full_res;
    } t_result;

    typedef struct packed {
        logic                  func;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [VALUE_BITS-1:0] value_in;
        logic                  typed;
        t_result               want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    ckim_req_if req_if ();
    ckim_rsp_if rsp_if ();

    coordinate_keyed_index_map dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the table
    logic [COORD_BITS-1:0] key_col_mem [ENTRIES];
    logic [COORD_BITS-1:0] key_row_mem [ENTRIES];
    logic [VALUE_BITS-1:0] index_mem   [ENTRIES];
    int                    key_count;

    t_result pending_results [$];
    t_row    dir_rows [$];
    logic [COORD_BITS-1:0] pool_col [KEY_POOL];
    logic [COORD_BITS-1:0] pool_row [KEY_POOL];

    int n_accepted;
    int n_mismatch;
    int cycle_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one access to the shadow table and returns the result it causes
    function automatic t_result map_access(input logic func,
                                           input logic [COORD_BITS-1:0] col,
                                           input logic [COORD_BITS-1:0] row,
                                           input logic [VALUE_BITS-1:0] val);
        t_result r;
        int      hit;
        r   = '0;
        hit = -1;
        // lowest matching entry wins; valid entries are 0 .. key_count-1
        for (int k = 0; k < key_count; k++) begin
            if (hit < 0 && key_col_mem[k] == col && key_row_mem[k] == row) hit = k;
        end
        r.found = (hit >= 0);
        if (func == FUNC_LOOKUP) begin
            if (hit >= 0) r.value_out = index_mem[hit];
        end else if (hit >= 0) begin
            index_mem[hit] = val;
        end else if (key_count < ENTRIES) begin
            key_col_mem[key_count] = col;
            key_row_mem[key_count] = row;
            index_mem[key_count]   = val;
            key_count++;
        end else begin
            // table full: write dropped
            r.full_res = 1'b1;
        end
        return r;
    endfunction

    // Idle-free windows: one in the middle, and the tail of the run
    function automatic bit quiet_phase(input int n);
        return (n >= 600 && n < 700) || (n >= N_ITEMS - 150);
    endfunction

    task automatic add_row(input logic func, input int col, input int row, input int val,
                           input logic typed, input logic found, input int vout,
                           input logic full);
        t_row r;
        r.func            = func;
        r.col             = col[COORD_BITS-1:0];
        r.row             = row[COORD_BITS-1:0];
        r.value_in        = val[VALUE_BITS-1:0];
        r.typed           = typed;
        r.want.found      = found;
        r.want.value_out  = vout[VALUE_BITS-1:0];
        r.want.full_res   = full;
        dir_rows.push_back(r);
    endtask

    task automatic flag_mismatch(input string name, input int want, input int got);
        n_mismatch++;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
    endtask

    // Scoreboard: check results, then predict for newly taken items
    always @(posedge i_clk) begin
        t_result pred;
        t_result want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    n_mismatch++;
                    $error("result item with no expectation");
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.found !== want.found)
                        flag_mismatch("found", want.found, rsp_if.found);
                    if (rsp_if.value_out !== want.value_out)
                        flag_mismatch("value_out", want.value_out, rsp_if.value_out);
                    if (rsp_if.full_res !== want.full_res)
                        flag_mismatch("full_res", want.full_res, rsp_if.full_res);
                end
            end
            if (req_if.valid && req_if.ready) begin
                pred = map_access(req_if.func, req_if.col, req_if.row, req_if.value_in);
                if (n_accepted < dir_rows.size() && dir_rows[n_accepted].typed)
                    pending_results.push_back(dir_rows[n_accepted].want);
                else
                    pending_results.push_back(pred);
                n_accepted++;
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stall bursts plus one long hold-off
    initial begin
        bit held;
        held = 1'b0;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && n_accepted >= HOLD_AT) begin
                // long stall so the chain fills and the input backs up
                held = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!quiet_phase(n_accepted) && $urandom_range(0, 4) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        t_row item;
        int   gap;
        int   pick;

        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.func     = FUNC_LOOKUP;
        req_if.col      = '0;
        req_if.row      = '0;
        req_if.value_in = '0;
        key_count       = 0;
        n_accepted      = 0;
        n_mismatch      = 0;

        // directed rows: corners of the key space, hits, misses, updates
        add_row(FUNC_LOOKUP, 0,     0,     'hFFFF, 1, 0, 0,      0);
        add_row(FUNC_LOOKUP, 4095,  4095,  'h0000, 1, 0, 0,      0);
        add_row(FUNC_INSERT, 0,     0,     'hFFFF, 1, 0, 0,      0);
        add_row(FUNC_LOOKUP, 0,     0,     'h0000, 1, 1, 'hFFFF, 0);
        add_row(FUNC_INSERT, 4095,  4095,  'h0000, 1, 0, 0,      0);
        add_row(FUNC_LOOKUP, 4095,  4095,  'hFFFF, 1, 1, 0,      0);
        add_row(FUNC_LOOKUP, 4095,  0,     'h0000, 1, 0, 0,      0);
        add_row(FUNC_LOOKUP, 0,     4095,  'h0000, 1, 0, 0,      0);
        add_row(FUNC_INSERT, 0,     0,     'h1234, 1, 1, 0,      0);
        add_row(FUNC_LOOKUP, 0,     0,     'h0000, 1, 1, 'h1234, 0);
        add_row(FUNC_INSERT, 4095,  0,     'hAAAA, 1, 0, 0,      0);
        add_row(FUNC_INSERT, 0,     4095,  'h5555, 1, 0, 0,      0);
        add_row(FUNC_LOOKUP, 4095,  0,     'h0000, 1, 1, 'hAAAA, 0);
        add_row(FUNC_LOOKUP, 0,     4095,  'h0000, 1, 1, 'h5555, 0);
        add_row(FUNC_INSERT, 'hA5A, 'h5A5, 'h8001, 0, 0, 0,      0);
        add_row(FUNC_LOOKUP, 'hA5A, 'h5A5, 'h0000, 0, 0, 0,      0);
        add_row(FUNC_INSERT, 'hA5A, 'h5A5, 'h7FFE, 0, 0, 0,      0);
        add_row(FUNC_LOOKUP, 'hA5A, 'h5A5, 'hFFFF, 0, 0, 0,      0);
        add_row(FUNC_LOOKUP, 'h5A5, 'hA5A, 'h0000, 0, 0, 0,      0);
        add_row(FUNC_INSERT, 4095,  4095,  'hFFFF, 1, 1, 0,      0);
        add_row(FUNC_LOOKUP, 4095,  4095,  'h0000, 1, 1, 'hFFFF, 0);

        // key pool for random items, sized past the table so it fills and overflows
        for (int k = 0; k < KEY_POOL; k++) begin
            pool_col[k] = COORD_BITS'($urandom());
            pool_row[k] = COORD_BITS'($urandom());
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_ITEMS; n++) begin
            if (n < dir_rows.size()) begin
                item = dir_rows[n];
            end else begin
                item.func = ($urandom_range(0, 99) < 55) ? FUNC_INSERT : FUNC_LOOKUP;
                if ($urandom_range(0, 99) < 70) begin
                    pick     = $urandom_range(0, KEY_POOL - 1);
                    item.col = pool_col[pick];
                    item.row = pool_row[pick];
                end else begin
                    item.col = COORD_BITS'($urandom());
                    item.row = COORD_BITS'($urandom());
                end
                item.value_in = VALUE_BITS'($urandom());
            end

            gap = 0;
            if (!quiet_phase(n) && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
            if (gap > 0) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end

            @(negedge i_clk);
            req_if.valid    <= 1'b1;
            req_if.func     <= item.func;
            req_if.col      <= item.col;
            req_if.row      <= item.row;
            req_if.value_in <= item.value_in;
            do @(posedge i_clk); while (!req_if.ready);
        end
        @(negedge i_clk);
        req_if.valid <= 1'b0;

        // drain: every expected result in, then watch for strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/ckim_pkg.sv
rtl/ckim_req_if.sv
rtl/ckim_rsp_if.sv
rtl/ckim_cell.sv
rtl/coordinate_keyed_index_map.sv
tb/tb.sv
